>>> src/ksh_pkg.sv
// ----------------------------------------------------------------------------
// ksh_pkg
// Shared constants and control types for the k-th smallest heap selector.
// ----------------------------------------------------------------------------
package ksh_pkg;

	localparam int MAX_RANK   = 64;
	localparam int VALUE_BITS = 32;
	localparam int ADDR_W     = $clog2(MAX_RANK);
	localparam int CNT_W      = $clog2(MAX_RANK + 1);
	localparam int IDX_W      = ADDR_W + 2;
	localparam int RANK_W     = 7;
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 3;

	localparam logic [RANK_W-1:0]     RANK_RESET = RANK_W'(1);
	localparam logic [VALUE_BITS-1:0] NOT_FOUND  = '1;

	// register index codes, taken from paddr[2]
	localparam logic [0:0] REG_RANK_K = 1'b0;

	typedef struct packed {
		logic accept;
		logic up_read;
		logic up_step;
		logic dn_read;
		logic dn_step;
		logic load_out;
	} ksh_cmd_t;

	typedef struct packed {
		logic do_insert;
		logic do_replace;
		logic in_last;
		logic last;
		logic pos_zero;
		logic up_done;
		logic dn_leaf;
		logic dn_done;
		logic out_free;
	} ksh_status_t;

endpackage

>>> src/ksh_if.sv
// ----------------------------------------------------------------------------
// ksh channel interfaces
// Valid/ready channels for samples in and selection results out.
// ----------------------------------------------------------------------------
interface ksh_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               end_of_set;

	modport source (output valid, output sample_value, output end_of_set, input ready);
	modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface ksh_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] kth_value;
	logic               found;

	modport source (output valid, output kth_value, output found, input ready);
	modport sink   (input valid, input kth_value, input found, output ready);
endinterface

>>> src/ksh_ram.sv
// ----------------------------------------------------------------------------
// ksh_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ksh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> src/ksh_dp.sv
// ----------------------------------------------------------------------------
// ksh_dp
// Heap datapath: heap RAM, sift position, fill count and result register.
// ----------------------------------------------------------------------------
module ksh_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ksh_pkg::ksh_cmd_t                   cmd,
	output ksh_pkg::ksh_status_t                status,
	input  logic [ksh_pkg::RANK_W-1:0]          rank_k,
	input  logic signed [31:0]                  sample_value,
	input  logic                                end_of_set,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [31:0]                  kth_value,
	output logic                                found
);

	logic signed [ksh_pkg::VALUE_BITS-1:0] v_q;
	logic signed [ksh_pkg::VALUE_BITS-1:0] root_q;
	logic                                  last_q;
	logic [ksh_pkg::ADDR_W-1:0]            pos_q;
	logic [ksh_pkg::CNT_W-1:0]             fill_q;
	logic                                  out_valid_q;
	logic signed [31:0]                    kth_value_q;
	logic                                  found_q;

	logic                                  rank_ok;
	logic signed [ksh_pkg::VALUE_BITS-1:0] in_val;
	logic [ksh_pkg::ADDR_W-1:0]            parent;
	logic [ksh_pkg::IDX_W-1:0]             l_idx;
	logic [ksh_pkg::IDX_W-1:0]             r_idx;
	logic [ksh_pkg::IDX_W-1:0]             lim;
	logic [ksh_pkg::VALUE_BITS-1:0]        rd_a;
	logic [ksh_pkg::VALUE_BITS-1:0]        rd_b;
	logic signed [ksh_pkg::VALUE_BITS-1:0] lv;
	logic signed [ksh_pkg::VALUE_BITS-1:0] rv;
	logic signed [ksh_pkg::VALUE_BITS-1:0] best;
	logic                                  pick_l;
	logic                                  pick_r;
	logic                                  we;
	logic [ksh_pkg::ADDR_W-1:0]            waddr;
	logic [ksh_pkg::VALUE_BITS-1:0]        wdata;
	logic                                  res_found;

	assign in_val  = ksh_pkg::VALUE_BITS'(sample_value);
	assign rank_ok = (rank_k != '0) && (rank_k <= ksh_pkg::RANK_W'(ksh_pkg::MAX_RANK));
	assign parent  = (pos_q - ksh_pkg::ADDR_W'(1)) >> 1;
	assign l_idx   = ksh_pkg::IDX_W'({pos_q, 1'b1});
	assign r_idx   = l_idx + ksh_pkg::IDX_W'(1);
	assign lim     = ksh_pkg::IDX_W'(fill_q);

	assign lv     = $signed(rd_a);
	assign rv     = $signed(rd_b);
	assign pick_l = lv > v_q;
	assign best   = pick_l ? lv : v_q;
	assign pick_r = (r_idx < lim) && (rv > best);

	assign status.do_insert  = rank_ok && (ksh_pkg::RANK_W'(fill_q) < rank_k);
	assign status.do_replace = rank_ok && (ksh_pkg::RANK_W'(fill_q) >= rank_k)
		&& (fill_q != '0) && (in_val < root_q);
	assign status.in_last    = end_of_set;
	assign status.last       = last_q;
	assign status.pos_zero   = (pos_q == '0);
	assign status.up_done    = lv >= v_q;
	assign status.dn_leaf    = l_idx >= lim;
	assign status.dn_done    = !pick_l && !pick_r;
	assign status.out_free   = !out_valid_q || out_ready;

	assign res_found = rank_ok && (ksh_pkg::RANK_W'(fill_q) == rank_k);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = v_q;
		if (cmd.up_read && status.pos_zero) begin
			we = 1'b1;
		end
		if (cmd.up_step) begin
			we = 1'b1;
			if (!status.up_done) begin
				wdata = rd_a;
			end
		end
		if (cmd.dn_read && status.dn_leaf) begin
			we = 1'b1;
		end
		if (cmd.dn_step) begin
			we = 1'b1;
			if (!status.dn_done) begin
				wdata = pick_r ? rd_b : rd_a;
			end
		end
	end

	ksh_ram #(
		.WIDTH (ksh_pkg::VALUE_BITS),
		.DEPTH (ksh_pkg::MAX_RANK)
	) u_heap_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (cmd.up_read ? parent : l_idx[ksh_pkg::ADDR_W-1:0]),
		.raddr_b (r_idx[ksh_pkg::ADDR_W-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && status.do_insert) begin
				fill_q <= fill_q + ksh_pkg::CNT_W'(1);
			end
			if (cmd.load_out) begin
				fill_q      <= '0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			v_q    <= in_val;
			last_q <= end_of_set;
			pos_q  <= status.do_insert ? fill_q[ksh_pkg::ADDR_W-1:0] : '0;
		end
		if (cmd.up_step && !status.up_done) begin
			pos_q <= parent;
		end
		if (cmd.dn_step && !status.dn_done) begin
			pos_q <= pick_r ? r_idx[ksh_pkg::ADDR_W-1:0] : l_idx[ksh_pkg::ADDR_W-1:0];
		end
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
		if (cmd.load_out) begin
			found_q     <= res_found;
			kth_value_q <= 32'(res_found ? root_q : ksh_pkg::NOT_FOUND);
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = kth_value_q;
	assign found     = found_q;

endmodule

>>> src/ksh_ctrl.sv
// ----------------------------------------------------------------------------
// ksh_ctrl
// Controller for insert with sift-up, root replace with sift-down and result.
// ----------------------------------------------------------------------------
module ksh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ksh_pkg::ksh_status_t status,
	output ksh_pkg::ksh_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_DN,
		S_DN_CMP,
		S_RES
	} state_t;

	state_t state_q;
	state_t finish;

	assign finish   = status.last ? S_RES : S_IDLE;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.up_read  = (state_q == S_UP);
		cmd.up_step  = (state_q == S_UP_CMP);
		cmd.dn_read  = (state_q == S_DN);
		cmd.dn_step  = (state_q == S_DN_CMP);
		cmd.load_out = (state_q == S_RES) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (status.do_insert) begin
							state_q <= S_UP;
						end else if (status.do_replace) begin
							state_q <= S_DN;
						end else if (status.in_last) begin
							state_q <= S_RES;
						end
					end
				end
				S_UP: begin
					state_q <= status.pos_zero ? finish : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= status.up_done ? finish : S_UP;
				end
				S_DN: begin
					state_q <= status.dn_leaf ? finish : S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= status.dn_done ? finish : S_DN;
				end
				S_RES: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/kth_smallest_max_heap_select.sv
// ----------------------------------------------------------------------------
// kth_smallest_max_heap_select
// Streams signed samples through a bounded max-heap and reports the k-th
// smallest sample of each set.
//
//   channel     dir   handshake            payload
//   sample_ch   in    valid/ready          sample_value, end_of_set
//   result_ch   out   valid/ready          kth_value, found
//   apb         in    psel/penable/pready  paddr, pwdata, prdata (rank_k)
//
// A sample that leaves the heap alone is taken in the idle state alone. An insert or a root
// replace then walks the heap one level at a time, each level a read state then a
// compare-and-write state, set by the registered read of the heap RAM.
// A last sample then loads the result register, which holds the result while
// the next set streams in; that load waits while the register is full.
// Reset clears the fill count and sets rank_k to 1; the heap RAM is not cleared.
// ----------------------------------------------------------------------------
module kth_smallest_max_heap_select (
	input  logic                         clk,
	input  logic                         arst_n,
	ksh_in_if.sink                       sample_ch,
	ksh_out_if.source                    result_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ksh_pkg::PADDR_W-1:0]  paddr,
	input  logic [ksh_pkg::DATA_W-1:0]   pwdata,
	output logic [ksh_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	logic [ksh_pkg::RANK_W-1:0] rank_k_q;
	ksh_pkg::ksh_cmd_t          cmd;
	ksh_pkg::ksh_status_t       status;
	logic                       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_k_q <= ksh_pkg::RANK_RESET;
		end else if (cfg_wr && (paddr[2] == ksh_pkg::REG_RANK_K)) begin
			rank_k_q <= pwdata[ksh_pkg::RANK_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			ksh_pkg::REG_RANK_K: prdata = ksh_pkg::DATA_W'(rank_k_q);
			default:             prdata = '0;
		endcase
	end

	ksh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	ksh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.rank_k       (rank_k_q),
		.sample_value (sample_ch.sample_value),
		.end_of_set   (sample_ch.end_of_set),
		.out_ready    (result_ch.ready),
		.out_valid    (result_ch.valid),
		.kth_value    (result_ch.kth_value),
		.found        (result_ch.found)
	);

	// result register only loads when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result loaded over a pending transfer");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> result_ch.valid)
		else $error("loaded result not presented");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.up_read, cmd.up_step, cmd.dn_read, cmd.dn_step,
			cmd.load_out}))
		else $error("more than one datapath command");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.up_step || cmd.dn_step) |-> !sample_ch.ready)
		else $error("sample accepted during a sift");

endmodule

>>> verif/tb_kth_smallest_max_heap_select.sv
// ----------------------------------------------------------------------------
// tb_kth_smallest_max_heap_select
// Streams sets of signed samples into the selector under several rank
// settings and checks every result against a behavioral max-heap kept in the
// testbench. The settings include rank zero, ranks above the heap depth,
// and rank changes in the middle of a set. Both channels idle at random,
// and the result side stops once for a long stretch.
// ----------------------------------------------------------------------------
module tb_kth_smallest_max_heap_select;
	import ksh_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 200;
	localparam int RANDOM_ITEMS  = 500;

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic                         is_last;
	} sample_t;

	typedef struct {
		logic signed [VALUE_BITS-1:0] kth_value;
		logic                         found;
	} selection_t;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic                         in_valid  = 1'b0;
	logic signed [VALUE_BITS-1:0] in_value  = '0;
	logic                         in_last   = 1'b0;
	logic                         out_ready = 1'b0;

	ksh_in_if  sample_if ();
	ksh_out_if result_if ();

	assign sample_if.valid        = in_valid;
	assign sample_if.sample_value = in_value;
	assign sample_if.end_of_set   = in_last;
	assign result_if.ready        = out_ready;

	kth_smallest_max_heap_select i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_if),
		.result_ch (result_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// heap mirror and rank copy
	logic signed [VALUE_BITS-1:0] heap_mirror [MAX_RANK];
	int                           heap_fill = 0;
	logic [RANK_W-1:0]            rank_sel  = RANK_RESET;

	selection_t kth_expect_q [$];
	sample_t    sample_q [$];

	int src_wait     = 0;
	int snk_wait     = 0;
	bit src_gaps     = 1'b1;
	bit snk_gaps     = 1'b1;
	int hold_reqs    = 0;
	int holds_served = 0;

	int fail_count    = 0;
	int n_items       = 0;
	int n_sent        = 0;
	int n_sets        = 0;
	int n_found       = 0;
	int n_missing     = 0;
	int n_rank_writes = 0;

	task automatic absorb_sample(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
		int                           pos, par, big, lc, rc;
		logic signed [VALUE_BITS-1:0] tmp;
		bit                           done;
		selection_t                   sel;
		if (rank_sel != 0 && rank_sel <= MAX_RANK) begin
			if (heap_fill < rank_sel) begin
				heap_mirror[heap_fill] = v;
				pos = heap_fill;
				heap_fill++;
				done = 1'b0;
				while (pos > 0 && !done) begin
					par = (pos - 1) / 2;
					if (heap_mirror[par] >= heap_mirror[pos]) begin
						done = 1'b1;
					end else begin
						tmp              = heap_mirror[par];
						heap_mirror[par] = heap_mirror[pos];
						heap_mirror[pos] = tmp;
						pos              = par;
					end
				end
			end else if (heap_fill > 0 && v < heap_mirror[0]) begin
				heap_mirror[0] = v;
				pos  = 0;
				done = 1'b0;
				while (!done) begin
					big = pos;
					lc  = 2 * pos + 1;
					rc  = 2 * pos + 2;
					if (lc < heap_fill && heap_mirror[lc] > heap_mirror[big])
						big = lc;
					if (rc < heap_fill && heap_mirror[rc] > heap_mirror[big])
						big = rc;
					if (big == pos) begin
						done = 1'b1;
					end else begin
						tmp              = heap_mirror[pos];
						heap_mirror[pos] = heap_mirror[big];
						heap_mirror[big] = tmp;
						pos              = big;
					end
				end
			end
		end
		if (is_last) begin
			if (rank_sel != 0 && rank_sel <= MAX_RANK && heap_fill == rank_sel) begin
				sel.kth_value = heap_mirror[0];
				sel.found     = 1'b1;
				n_found++;
			end else begin
				sel.kth_value = NOT_FOUND;
				sel.found     = 1'b0;
				n_missing++;
			end
			kth_expect_q.push_back(sel);
			heap_fill = 0;
		end
	endtask

	function automatic logic signed [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
					1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return int'($urandom_range(0, 15)) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_sample(input logic signed [VALUE_BITS-1:0] v, input logic is_last);
		sample_t s;
		s.value   = v;
		s.is_last = is_last;
		sample_q.push_back(s);
		n_sent++;
		if (rank_sel != 0 && rank_sel <= MAX_RANK)
			n_items++;
		if (is_last)
			n_sets++;
	endtask

	task automatic send_run(input int n, input bit close_set);
		for (int i = 0; i < n; i++)
			push_sample(rand_value(), close_set && i == n - 1);
	endtask

	// wait for every transfer and result, then for the block to go quiet
	task automatic settle();
		do @(negedge clk);
		while (sample_q.size() != 0 || sample_if.valid || kth_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rank(input logic [RANK_W-1:0] k);
		settle();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({REG_RANK_K, 2'b00});
		pwdata  <= DATA_W'(k);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		rank_sel = k;
		n_rank_writes++;
	endtask

	always @(posedge clk) begin : sample_drive
		sample_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_wait <= 0;
		end else if (!in_valid || sample_if.ready) begin
			if (src_wait != 0) begin
				in_valid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (sample_q.size() != 0) begin
				nxt = sample_q.pop_front();
				in_valid <= 1'b1;
				in_value <= nxt.value;
				in_last  <= nxt.is_last;
				src_wait <= src_gaps ? $urandom_range(0, 7) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : sample_watch
		if (arst_n && sample_if.valid && sample_if.ready)
			absorb_sample(sample_if.sample_value, sample_if.end_of_set);
	end

	always @(posedge clk) begin : result_accept
		int n;
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_wait  <= 0;
		end else if (holds_served != hold_reqs) begin
			holds_served <= holds_served + 1;
			snk_wait     <= LONG_HOLD;
			out_ready    <= 1'b0;
		end else if (result_if.valid && out_ready) begin
			n = snk_gaps ? $urandom_range(0, 7) : 0;
			snk_wait  <= n;
			out_ready <= (n == 0);
		end else if (snk_wait > 1) begin
			snk_wait  <= snk_wait - 1;
			out_ready <= 1'b0;
		end else begin
			snk_wait  <= 0;
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		selection_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (kth_expect_q.size() == 0) begin
				$display("%0t: result with none expected, kth_value %0d found %0b",
					$time, result_if.kth_value, result_if.found);
				fail_count++;
			end else begin
				want = kth_expect_q.pop_front();
				if (result_if.kth_value !== want.kth_value) begin
					$display("%0t: kth_value expected %0d actual %0d",
						$time, want.kth_value, result_if.kth_value);
					fail_count++;
				end
				if (result_if.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b",
						$time, want.found, result_if.found);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int k, nsets, len, cut;
		bit wide_done;
		wide_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rank 1 out of reset, extremes of the value range
		push_sample({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
		push_sample({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
		push_sample(32'sd42, 1'b1);

		// rank zero
		set_rank(RANK_W'(0));
		push_sample(32'sd5, 1'b1);

		// too few samples, then duplicates around the root
		set_rank(RANK_W'(3));
		push_sample(32'sd1, 1'b0);
		push_sample(32'sd2, 1'b1);
		push_sample(32'sd9, 1'b0);
		push_sample(-32'sd5, 1'b0);
		push_sample(-32'sd5, 1'b0);
		push_sample(32'sd8, 1'b0);
		push_sample({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
		push_sample({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b1);

		// rank above the heap depth
		set_rank(RANK_W'(127));
		push_sample(32'sd1, 1'b0);
		push_sample(32'sd2, 1'b1);

		// rank lowered mid-set, fill stays above the rank
		set_rank(RANK_W'(4));
		push_sample(32'sd10, 1'b0);
		push_sample(32'sd20, 1'b0);
		push_sample(32'sd30, 1'b0);
		push_sample(32'sd40, 1'b0);
		set_rank(RANK_W'(2));
		push_sample(32'sd7, 1'b1);

		// rank lowered mid-set to the current fill
		set_rank(RANK_W'(3));
		push_sample(32'sd3, 1'b0);
		push_sample(32'sd1, 1'b0);
		set_rank(RANK_W'(2));
		push_sample(32'sd2, 1'b1);

		// rank raised mid-set
		push_sample(32'sd6, 1'b0);
		push_sample(32'sd4, 1'b0);
		push_sample(32'sd9, 1'b0);
		set_rank(RANK_W'(5));
		push_sample(32'sd1, 1'b0);
		push_sample(-32'sd2, 1'b0);
		push_sample(32'sd8, 1'b1);

		// result side stops while short sets keep coming
		set_rank(RANK_W'(3));
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		hold_reqs++;
		repeat (20)
			send_run($urandom_range(1, 4), 1'b1);

		while (n_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: k = 0;
				1: k = $urandom_range(MAX_RANK + 1, 127);
				2: k = wide_done ? $urandom_range(1, 8) : MAX_RANK;
				3: k = $urandom_range(9, 24);
				default: k = $urandom_range(1, 8);
			endcase
			if (k == MAX_RANK)
				wide_done = 1'b1;
			set_rank(RANK_W'(k));
			src_gaps = $urandom_range(0, 3) != 0;
			snk_gaps = $urandom_range(0, 3) != 0;
			nsets = (k > 24) ? 2 : $urandom_range(2, 6);
			repeat (nsets) begin
				if (k == 0 || k > MAX_RANK)
					len = $urandom_range(1, 4);
				else if ($urandom_range(0, 3) == 0)
					len = $urandom_range(1, k);
				else
					len = $urandom_range(k, k + 6);
				if (len > 1 && $urandom_range(0, 7) == 0) begin
					cut = $urandom_range(1, len - 1);
					send_run(cut, 1'b0);
					k = $urandom_range(1, 10);
					set_rank(RANK_W'(k));
					send_run(len - cut, 1'b1);
				end else begin
					send_run(len, 1'b1);
				end
			end
		end

		settle();
		$display("covered %0d samples, %0d of them heap samples, in %0d sets over %0d rank writes",
			n_sent, n_items, n_sets, n_rank_writes);
		$display("selections: %0d found, %0d not found", n_found, n_missing);
		if (fail_count == 0) begin
			$display("** kth_smallest_max_heap_select: PASSED **");
		end else begin
			$display("** kth_smallest_max_heap_select: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("%0t: timeout with %0d results outstanding", $time, kth_expect_q.size());
		$display("** kth_smallest_max_heap_select: FAILED **");
		$finish;
	end

endmodule
